/* hdl/bsw_pkg.sv */
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared constants and types of the byte pattern search block.
// ----------------------------------------------------------------------------
package bsw_pkg;

    // Default sizes
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = 8'd3;

    // Fixed field widths
    localparam int PATTERN_BITS = 128;
    localparam int LENGTH_W     = 5;
    localparam int OFFSET_W     = 32;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LENGTH_W-1:0]     length;
        logic [OFFSET_W-1:0]     start_offset;
    } cfg_t;

    // One search result
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

endpackage

/* hdl/bsw_match.sv */
// ----------------------------------------------------------------------------
// bsw_match
// Parallel compare of the byte window plus the current byte against the
// configured pattern; flags a pattern that ends on the current byte.
// ----------------------------------------------------------------------------
module bsw_match #(
    parameter int PATTERN_MAX = bsw_pkg::PATTERN_MAX_DEF,
    parameter int WIN_DEPTH   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  bsw_pkg::cfg_t     cfg,
    input  logic [7:0]        cur_byte,
    input  logic [7:0]        window [WIN_DEPTH],
    input  logic [LEN_W-1:0]  fill,
    output logic [LEN_W-1:0]  len_eff,
    output logic              hit
);
    import bsw_pkg::*;

    logic [7:0]       w [PATTERN_MAX];
    logic             all_eq;
    logic             len_hit;
    logic             fill_ok;

    // Clamp the length to the pattern store
    always_comb
    begin
        if (cfg.length > LENGTH_W'(PATTERN_MAX))
            len_eff = LEN_W'(PATTERN_MAX);
        else
            len_eff = cfg.length[LEN_W-1:0];
    end

    // Enough bytes seen for the pattern to fit inside the buffer
    assign fill_ok = ({1'b0, fill} + (LEN_W+1)'(1)) >= {1'b0, len_eff};

    // Compare every candidate length, pick the configured one
    always_comb
    begin
        w[0] = cur_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
            w[j] = window[j-1];
        len_hit = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            all_eq = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (w[l-1-k] != cfg.pattern[k*8 +: 8])
                    all_eq = 1'b0;
            end
            if (len_eff == LEN_W'(l) && all_eq)
                len_hit = 1'b1;
        end
    end

    assign hit = (len_eff != '0) && fill_ok && len_hit;

endmodule

/* hdl/bsw_track.sv */
// ----------------------------------------------------------------------------
// bsw_track
// Stream state: byte window, fill count, position and the first matches
// anywhere and at or after the start offset; forms the result on the last
// byte and clears for the next buffer.
// ----------------------------------------------------------------------------
module bsw_track #(
    parameter int PATTERN_MAX = bsw_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = bsw_pkg::OFFSET_BITS_DEF,
    parameter int WIN_DEPTH   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   cur_byte,
    input  logic                         last,
    input  logic                         hit,
    input  logic [LEN_W-1:0]             len_eff,
    input  logic [bsw_pkg::OFFSET_W-1:0] start_offset,
    output logic [7:0]                   window [WIN_DEPTH],
    output logic [LEN_W-1:0]             fill,
    output bsw_pkg::result_t             result
);
    import bsw_pkg::*;

    logic [7:0]             window_reg [WIN_DEPTH];
    logic [LEN_W-1:0]       fill_reg;
    logic [OFFSET_BITS-1:0] position_reg;
    logic                   any_seen_reg;
    logic [OFFSET_BITS-1:0] first_any_reg;
    logic                   after_seen_reg;
    logic [OFFSET_BITS-1:0] first_after_reg;

    logic [OFFSET_BITS-1:0] match_off;
    logic                   any_seen_next;
    logic [OFFSET_BITS-1:0] first_any_next;
    logic                   after_seen_next;
    logic [OFFSET_BITS-1:0] first_after_next;

    assign window = window_reg;
    assign fill   = fill_reg;

    // Start offset of a match that ends on the current byte
    assign match_off = position_reg - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);

    // Record the first matches
    always_comb
    begin
        any_seen_next    = any_seen_reg;
        first_any_next   = first_any_reg;
        after_seen_next  = after_seen_reg;
        first_after_next = first_after_reg;
        if (hit && !any_seen_reg)
        begin
            any_seen_next  = 1'b1;
            first_any_next = match_off;
        end
        if (hit && !after_seen_reg && (OFFSET_W'(match_off) >= start_offset))
        begin
            after_seen_next  = 1'b1;
            first_after_next = match_off;
        end
    end

    // Choose forward match, else wrapped match, else not found
    always_comb
    begin
        if (after_seen_next)
        begin
            result.found        = 1'b1;
            result.match_offset = OFFSET_W'(first_after_next);
        end
        else if (any_seen_next)
        begin
            result.found        = 1'b1;
            result.match_offset = OFFSET_W'(first_any_next);
        end
        else
        begin
            result.found        = 1'b0;
            result.match_offset = '0;
        end
    end

    // Shift the window
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            window_reg[0] <= cur_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
                window_reg[i] <= window_reg[i-1];
        end
    end

    // Advance position and match state, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            position_reg    <= '0;
            any_seen_reg    <= 1'b0;
            first_any_reg   <= '0;
            after_seen_reg  <= 1'b0;
            first_after_reg <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                fill_reg        <= '0;
                position_reg    <= '0;
                any_seen_reg    <= 1'b0;
                first_any_reg   <= '0;
                after_seen_reg  <= 1'b0;
                first_after_reg <= '0;
            end
            else
            begin
                if (fill_reg != LEN_W'(PATTERN_MAX))
                    fill_reg <= fill_reg + LEN_W'(1);
                position_reg    <= position_reg + OFFSET_BITS'(1);
                any_seen_reg    <= any_seen_next;
                first_any_reg   <= first_any_next;
                after_seen_reg  <= after_seen_next;
                first_after_reg <= first_after_next;
            end
        end
    end

    // A forward match is always also a match anywhere
    a_after_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
        after_seen_reg |-> any_seen_reg)
        else $error("forward match recorded without any match");

    // The last byte leaves a clean stream state
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> (position_reg == '0) && (fill_reg == '0) && !any_seen_reg)
        else $error("stream state not cleared after last byte");

    // Fill never passes the pattern store
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_W'(PATTERN_MAX))
        else $error("window fill out of range");

endmodule

/* hdl/byte_pattern_search_wrap.sv */
// ----------------------------------------------------------------------------
// byte_pattern_search_wrap
// Streaming byte pattern search with wrap-around: one result per buffer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the window compare and match update run
// once per cycle on the byte held in the input register.
// Result path: the last byte of a buffer passes the input register, then the
// result register; a last byte stalls while the previous result is not taken.
// Reset: rst_n clears configuration, stream counters and both valid flags.
// ----------------------------------------------------------------------------
module byte_pattern_search_wrap #(
    parameter int PATTERN_MAX = bsw_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = bsw_pkg::OFFSET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tlast,  // last_byte
    // Result out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // [31:0] match_offset
    output logic                           m_axis_tuser   // [0] found
);
    import bsw_pkg::*;

    localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int LEN_W     = $clog2(PATTERN_MAX + 1);

    cfg_t             cfg_reg;
    logic             st_valid_reg;
    logic [7:0]       st_data_reg;
    logic             st_last_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;

    logic             st_fire;
    logic [7:0]       window [WIN_DEPTH];
    logic [LEN_W-1:0] fill;
    logic [LEN_W-1:0] len_eff;
    logic             hit;
    result_t          result;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    cfg_reg.pattern[63:0]   <= cfg_data;
                REG_PATTERN_HIGH:   cfg_reg.pattern[127:64] <= cfg_data;
                REG_PATTERN_LENGTH: cfg_reg.length          <= cfg_data[LENGTH_W-1:0];
                REG_START_OFFSET:   cfg_reg.start_offset    <= cfg_data[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    // Process the held byte unless its result has nowhere to go
    assign st_fire       = st_valid_reg && (!st_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !st_valid_reg || st_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (s_axis_tready)
            st_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            st_data_reg <= s_axis_tdata;
            st_last_reg <= s_axis_tlast;
        end
    end

    bsw_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .WIN_DEPTH   (WIN_DEPTH),
        .LEN_W       (LEN_W)
    ) u_match (
        .cfg      (cfg_reg),
        .cur_byte (st_data_reg),
        .window   (window),
        .fill     (fill),
        .len_eff  (len_eff),
        .hit      (hit)
    );

    bsw_track #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS),
        .WIN_DEPTH   (WIN_DEPTH),
        .LEN_W       (LEN_W)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (st_fire),
        .cur_byte     (st_data_reg),
        .last         (st_last_reg),
        .hit          (hit),
        .len_eff      (len_eff),
        .start_offset (cfg_reg.start_offset),
        .window       (window),
        .fill         (fill),
        .result       (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (st_fire && st_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (st_fire && st_last_reg)
            out_res_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.match_offset;
    assign m_axis_tuser  = out_res_reg.found;

    // A not-found result carries offset zero
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero offset");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        st_fire && st_last_reg |-> !out_valid_reg || m_axis_tready)
        else $error("pending result overwritten");

    // An accepted byte is held in the input register next cycle
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> st_valid_reg)
        else $error("accepted byte lost");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for byte_pattern_search_wrap. A bit-exact predictor of
// the window compare, the forward search and its wrap-around fallback is fed
// every accepted byte. Each buffer result is checked against the oldest
// pending prediction. Directed buffers cover the corner cases. Random
// buffers with planted, overlapping and truncated pattern copies follow.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bsw_pkg::*;

    localparam int ITEM_TARGET   = 1350;
    localparam int QUIET_ITEMS   = ITEM_TARGET * 85 / 100;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int MAX_REPORTS   = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] data_byte
    logic                   s_axis_tlast;   // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [31:0]            m_axis_tdata;   // [31:0] match_offset
    logic                   m_axis_tuser;   // [0] found

    // Shadow configuration
    logic [PATTERN_BITS-1:0] pat_bits;
    logic [LENGTH_W-1:0]     pat_len;
    logic [OFFSET_W-1:0]     fwd_start;

    // Shadow stream state
    logic [7:0]          win_bytes [0:PATTERN_MAX_DEF-2];
    logic [OFFSET_W-1:0] next_pos;
    int                  fill_count;
    bit                  hit_any;
    logic [OFFSET_W-1:0] hit_any_off;
    bit                  hit_fwd;
    logic [OFFSET_W-1:0] hit_fwd_off;

    result_t    pending_results [$];
    result_t    want;
    logic [7:0] buf_bytes [$];

    int  items_sent;
    int  buffers_sent;
    int  configs_done;
    int  n_forward;
    int  n_wrapped;
    int  n_missing;
    int  results_seen;
    int  mismatches;
    bit  quiet;

    byte_pattern_search_wrap u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 LIMIT_CYCLES, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // Clear the per-buffer search state
    function automatic void clear_stream();
        for (int i = 0; i < PATTERN_MAX_DEF - 1; i++)
            win_bytes[i] = 8'h00;
        next_pos    = '0;
        fill_count  = 0;
        hit_any     = 1'b0;
        hit_any_off = '0;
        hit_fwd     = 1'b0;
        hit_fwd_off = '0;
    endfunction

    // True when the pattern ends on the current byte
    function automatic bit pattern_ends_here(logic [7:0] cur, int len);
        logic [7:0] b;
        if (len == 0 || fill_count + 1 < len)
            return 1'b0;
        for (int k = 0; k < len; k++)
        begin
            b = (k == len - 1) ? cur : win_bytes[len - 2 - k];
            if (b != pat_bits[k*8 +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the search by one byte; returns 1 when a buffer result is due
    function automatic bit search_step(logic [7:0] cur, logic last, output result_t res);
        int                  len;
        logic [OFFSET_W-1:0] off;
        len = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
        res = '0;
        if (pattern_ends_here(cur, len))
        begin
            off = next_pos - OFFSET_W'(len - 1);
            if (!hit_any)
            begin
                hit_any     = 1'b1;
                hit_any_off = off;
            end
            if (!hit_fwd && off >= fwd_start)
            begin
                hit_fwd     = 1'b1;
                hit_fwd_off = off;
            end
        end
        for (int i = PATTERN_MAX_DEF - 2; i >= 1; i--)
            win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = cur;
        if (fill_count < PATTERN_MAX_DEF)
            fill_count++;
        next_pos = next_pos + 1'b1;
        if (!last)
            return 1'b0;
        if (hit_fwd)
        begin
            res.found        = 1'b1;
            res.match_offset = hit_fwd_off;
            n_forward++;
        end
        else if (hit_any)
        begin
            res.found        = 1'b1;
            res.match_offset = hit_any_off;
            n_wrapped++;
        end
        else
            n_missing++;
        clear_stream();
        return 1'b1;
    endfunction

    // Check each delivered result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with nothing pending: found=%0b offset=%0d",
                             $realtime, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_axis_tuser !== want.found || m_axis_tdata !== want.match_offset)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result %0d: expected found=%0b offset=%0d, ",
                                  "got found=%0b offset=%0d"},
                                 $realtime, results_seen, want.found, want.match_offset,
                                 m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // Result-side backpressure
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) < 3)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    // Send one item, with an optional idle burst ahead of it
    task automatic send_byte(logic [7:0] data, logic last);
        result_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (search_step(data, last, res))
            pending_results.insert(pending_results.size(), res);
        items_sent++;
        if (items_sent >= QUIET_ITEMS)
            quiet = 1'b1;
    endtask

    // Send buf_bytes as one buffer, last flag on the final byte
    task automatic send_buffer();
        for (int i = 0; i < buf_bytes.size(); i++)
            send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        buffers_sent++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:    pat_bits[63:0]   = val;
            REG_PATTERN_HIGH:   pat_bits[127:64] = val;
            REG_PATTERN_LENGTH: pat_len          = val[LENGTH_W-1:0];
            REG_START_OFFSET:   fwd_start        = val[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram the whole search while the block is idle
    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [LENGTH_W-1:0] len,
                             logic [OFFSET_W-1:0] start);
        wait_drained();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_START_OFFSET, CFG_DATA_W'(start));
        cfg_valid <= 1'b0;
        configs_done++;
    endtask

    // Zero-length pattern never matches, even on zero bytes
    task automatic test_empty_pattern();
        configure(64'h0, 64'h0, 5'd0, 32'd0);
        buf_bytes = '{8'h00, 8'hFF};
        send_buffer();
    endtask

    // One-byte pattern on a one-byte buffer
    task automatic test_single_byte();
        configure(64'hFF, 64'h0, 5'd1, 32'd0);
        buf_bytes = '{8'hFF};
        send_buffer();
    endtask

    // No match at or after start: fall back to the earliest; ignore the cut-off tail
    task automatic test_wrap_and_tail();
        configure(64'h0000_0000_0043_4241, {$urandom, $urandom}, 5'd3, 32'd1);
        buf_bytes = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42};
        send_buffer();
    endtask

    // Length above the maximum acts as the maximum; start far past the buffer
    task automatic test_oversized_length();
        logic [63:0] lo;
        lo = 64'hFF00_FF00_00FF_00FF;
        configure(lo, ~lo, 5'd31, 32'hFFFF_FFFF);
        buf_bytes.delete();
        for (int k = 0; k < 8; k++)
            buf_bytes.insert(buf_bytes.size(), lo[k*8 +: 8]);
        for (int k = 0; k < 8; k++)
            buf_bytes.insert(buf_bytes.size(), ~lo[k*8 +: 8]);
        send_buffer();
    endtask

    // Random configurations and buffers with planted pattern copies
    task automatic test_random_buffers();
        logic [63:0]         lo;
        logic [63:0]         hi;
        logic [LENGTH_W-1:0] len;
        logic [OFFSET_W-1:0] start;
        int                  eff;
        int                  target;
        int                  pick;
        bit                  noise;
        while (items_sent < ITEM_TARGET)
        begin
            lo   = {$urandom, $urandom};
            hi   = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = '0;
            else if (pick < 15)
                len = LENGTH_W'($urandom_range(PATTERN_MAX_DEF + 1, 31));
            else if (pick < 45)
                len = LENGTH_W'($urandom_range(1, 4));
            else
                len = LENGTH_W'($urandom_range(1, PATTERN_MAX_DEF));
            eff = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len);
            // Shrink the byte alphabet now and then so that repeats overlap
            if ($urandom_range(0, 3) == 0)
            begin
                lo = lo & 64'h0101_0101_0101_0101;
                hi = hi & 64'h0101_0101_0101_0101;
            end
            case ($urandom_range(0, 9)) inside
                [0:2]:   start = '0;
                3:       start = 32'hFFFF_FFFF;
                4:       start = $urandom;
                default: start = OFFSET_W'($urandom_range(0, 40));
            endcase
            configure(lo, hi, len, start);
            repeat ($urandom_range(1, 4))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    target = $urandom_range(1, 24);
                else if (pick < 92)
                    target = $urandom_range(25, 60);
                else
                    target = $urandom_range(1, 3);
                noise = ($urandom_range(0, 9) == 0);
                buf_bytes.delete();
                while (buf_bytes.size() < target)
                begin
                    pick = $urandom_range(0, 99);
                    if (!noise && eff > 0 && pick < 18)
                    begin
                        for (int k = 0; k < eff; k++)
                            buf_bytes.insert(buf_bytes.size(),
                                             k < 8 ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8]);
                    end
                    else if (!noise && eff > 0 && pick < 55)
                    begin
                        pick = $urandom_range(0, eff - 1);
                        buf_bytes.insert(buf_bytes.size(),
                                         pick < 8 ? lo[pick*8 +: 8] : hi[(pick-8)*8 +: 8]);
                    end
                    else
                        buf_bytes.insert(buf_bytes.size(), 8'($urandom_range(0, 255)));
                end
                // Cut the tail so that the final copy may run past the end
                while (buf_bytes.size() > target)
                    void'(buf_bytes.pop_back());
                send_buffer();
            end
        end
    endtask

    // Test sequence
    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        pat_bits  = '0;
        pat_len   = '0;
        fwd_start = '0;
        clear_stream();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_single_byte();
        test_wrap_and_tail();
        test_oversized_length();
        test_random_buffers();

        wait_drained();
        $display("Searched %0d buffers (%0d bytes) under %0d configurations.",
                 buffers_sent, items_sent, configs_done);
        $display("Results: %0d at or after start, %0d wrapped, %0d not found; %0d mismatches.",
                 n_forward, n_wrapped, n_missing, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
